### rtl/core/drre_pkg.sv
// Package: shared constants, types and codes of the diagonal run ratio extractor.
`timescale 1ns / 1ps

package drre_pkg;

  localparam int MAX_DIM     = 2048;
  localparam int FRAC_BITS   = 8;
  localparam int PIX_W       = 8;
  localparam int POS_W       = 11;
  localparam int RUN_W       = 12;
  localparam int RATIO_W     = 21;
  localparam int MAG_W       = RATIO_W - 1;
  localparam int DIVD_W      = RUN_W + FRAC_BITS;
  localparam int STEP_W      = $clog2(DIVD_W + 1);
  localparam int Q_DEPTH     = 4;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);
  localparam logic [RUN_W-1:0] RUN_MAX       = RUN_W'(MAX_DIM);
  localparam logic [PIX_W-1:0] THRESH_RESET  = PIX_W'(128);
  localparam logic [31:0]      RATIO_MAG_MAX = 32'((64'd1 << MAG_W) - 64'd1);

  // One class change waiting for its ratio.
  typedef struct packed {
    logic [RUN_W-1:0] earlier;
    logic [RUN_W-1:0] ended;
    logic             neg;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
  } edge_evt_t;

  // Queue status seen by the divider side.
  typedef struct packed {
    logic      empty;
    edge_evt_t head;
  } q_status_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIX,
    DIV_DONE
  } div_state_t;

endpackage

### rtl/core/drre_front.sv
// Front end: pixel classing, run tracking and class-change detection.
`timescale 1ns / 1ps

module drre_front import drre_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [PIX_W-1:0] cfg_thresh,
  input  logic             accept,
  input  logic [PIX_W-1:0] gray_pixel,
  input  logic [POS_W-1:0] column,
  input  logic [POS_W-1:0] row,
  output logic             push,
  output edge_evt_t        evt
);

  logic [PIX_W-1:0] thresh;
  logic             dark_class;
  logic             have_earlier;
  logic [RUN_W-1:0] earlier_length;
  logic [RUN_W-1:0] running_length;

  logic             start;
  logic             cls;
  logic             cur_class;
  logic             hist;
  logic [RUN_W-1:0] run;
  logic             change;
  logic [RUN_W-1:0] run_base;
  logic             have_earlier_next;
  logic [RUN_W-1:0] earlier_length_next;
  logic [RUN_W-1:0] running_length_next;

  always_comb begin
    start     = (column == '0) || (row == '0);
    cls       = gray_pixel < thresh;
    cur_class = start ? cls : dark_class;
    hist      = start ? 1'b0 : have_earlier;
    run       = start ? '0 : running_length;
    change    = cls != cur_class;
    run_base  = change ? '0 : run;
    // Saturate the run count.
    running_length_next = (run_base < RUN_MAX) ? run_base + RUN_W'(1) : run_base;
    earlier_length_next = change ? run : earlier_length;
    have_earlier_next   = change | hist;
    push        = accept & change & hist;
    evt.earlier = earlier_length;
    evt.ended   = run;
    evt.neg     = cls;
    evt.col     = column;
    evt.row     = row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh         <= THRESH_RESET;
      dark_class     <= 1'b0;
      have_earlier   <= 1'b0;
      earlier_length <= '0;
      running_length <= '0;
    end else begin
      if (cfg_we) begin
        thresh <= cfg_thresh;
      end
      if (accept) begin
        dark_class     <= cls;
        have_earlier   <= have_earlier_next;
        earlier_length <= earlier_length_next;
        running_length <= running_length_next;
      end
    end
  end

endmodule

### rtl/core/drre_queue.sv
// Short register queue of class-change events between front and divider.
`timescale 1ns / 1ps

module drre_queue import drre_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  edge_evt_t push_evt,
  input  logic      pop,
  output logic      full,
  output q_status_t status
);

  edge_evt_t         slots [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full         = count == QCNT_W'(Q_DEPTH);
  assign status.empty = count == '0;
  assign status.head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/drre_div.sv
// Back end: bit-serial restoring divider and result output register.
`timescale 1ns / 1ps

module drre_div import drre_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  q_status_t                 status,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RUN_W-1:0]          earlier_run,
  output logic [RUN_W-1:0]          ended_run,
  output logic signed [RATIO_W-1:0] signed_ratio,
  output logic [POS_W-1:0]          edge_column,
  output logic [POS_W-1:0]          edge_row
);

  div_state_t state;
  div_state_t state_next;

  logic [DIVD_W-1:0] quot;
  logic [RUN_W-1:0]  rem;
  logic [STEP_W-1:0] steps;
  logic              neg;

  logic [RUN_W:0]    trial_in;
  logic [RUN_W:0]    trial;
  logic              q_bit;
  logic [31:0]       q_ext;
  logic [MAG_W-1:0]  mag;

  always_comb begin
    trial_in = {rem, quot[DIVD_W-1]};
    trial    = trial_in - {1'b0, ended_run};
    q_bit    = trial_in >= {1'b0, ended_run};
    q_ext    = 32'(quot);
    mag      = (q_ext > RATIO_MAG_MAX) ? MAG_W'(RATIO_MAG_MAX) : q_ext[MAG_W-1:0];
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    out_valid  = 1'b0;
    case (state)
      DIV_IDLE: begin
        if (!status.empty) begin
          pop        = 1'b1;
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (steps == STEP_W'(1)) begin
          state_next = DIV_FIX;
        end
      end
      DIV_FIX: begin
        state_next = DIV_DONE;
      end
      DIV_DONE: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = DIV_IDLE;
        end
      end
      default: begin
        state_next = DIV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        earlier_run <= status.head.earlier;
        ended_run   <= status.head.ended;
        edge_column <= status.head.col;
        edge_row    <= status.head.row;
        neg         <= status.head.neg;
        quot        <= DIVD_W'(status.head.earlier) << FRAC_BITS;
        rem         <= '0;
        steps       <= STEP_W'(DIVD_W);
      end
      DIV_RUN: begin
        // Shift one dividend bit in, keep the quotient bit in its place.
        rem   <= q_bit ? trial[RUN_W-1:0] : trial_in[RUN_W-1:0];
        quot  <= {quot[DIVD_W-2:0], q_bit};
        steps <= steps - STEP_W'(1);
      end
      DIV_FIX: begin
        signed_ratio <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/diagonal_run_ratio_extractor_top.sv
// Top level of the diagonal run ratio extractor.
`timescale 1ns / 1ps

// Pixels arrive in diagonal scan order with their column and row; a pixel
// in column or row zero opens a new diagonal. The front end takes one pixel
// per cycle unless in_stall, classes it against dark_threshold, tracks run
// lengths, and pushes each class change (after the first on a diagonal)
// into a four-entry queue. The back end pops one event at a time and runs
// a one-bit-per-cycle restoring divider over the 20-bit dividend: load at
// pop, one divide step per dividend bit, sign fix, output. Pixels that
// cause no result flow at one per cycle unless in_stall, which rises only
// while the queue is full. A new event is popped only after the last
// result leaves. dark_threshold resets to 128 and is written through the
// cfg port, which is always ready; write it only while the block is idle.
module diagonal_run_ratio_extractor_top import drre_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration write channel.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [PIX_W-1:0]          dark_threshold,
  // Pixel input channel.
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [PIX_W-1:0]          gray_pixel,
  input  logic [POS_W-1:0]          column,
  input  logic [POS_W-1:0]          row,
  // Result output channel.
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [RUN_W-1:0]          earlier_run,
  output logic [RUN_W-1:0]          ended_run,
  output logic signed [RATIO_W-1:0] signed_ratio,
  output logic [POS_W-1:0]          edge_column,
  output logic [POS_W-1:0]          edge_row
);

  logic      q_full;
  logic      accept;
  logic      push;
  logic      pop;
  edge_evt_t evt;
  q_status_t q_status;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;
  // Hold off pixels while the queue has no room for a possible event.
  assign in_stall  = q_full;
  assign accept    = in_valid & ~q_full;

  drre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_thresh (dark_threshold),
    .accept     (accept),
    .gray_pixel (gray_pixel),
    .column     (column),
    .row        (row),
    .push       (push),
    .evt        (evt)
  );

  drre_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_evt (evt),
    .pop      (pop),
    .full     (q_full),
    .status   (q_status)
  );

  drre_div u_div (
    .clk          (clk),
    .rst          (rst),
    .status       (q_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .earlier_run  (earlier_run),
    .ended_run    (ended_run),
    .signed_ratio (signed_ratio),
    .edge_column  (edge_column),
    .edge_row     (edge_row)
  );

endmodule
